// ----- design/assert_macros.svh -----
// Assertion macros for the checker file.
// Each macro expands to one labeled concurrent assertion, sampled on the
// rising clock edge and disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- design/mcdw_pkg.sv -----
// ----------------------------------------------------------------------------
// mcdw_pkg
// Shared types and constants of the multi-channel deadline watchdog.
// ----------------------------------------------------------------------------
package mcdw_pkg;

    localparam int CHANNELS_DEFAULT = 8;
    localparam int MAX_RESULTS      = 8;
    localparam int S_TDATA_W        = 72;
    localparam int M_TDATA_W        = 24;
    localparam int COUNT_W          = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        CMD_REGISTER = 3'd0,
        CMD_START    = 3'd1,
        CMD_END      = 3'd2,
        CMD_RECOVER  = 3'd3,
        CMD_CHECK    = 3'd4,
        CMD_STOP_ALL = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OP,
        ST_CHECK,
        ST_FLUSH
    } state_t;

    // One channel entry of the table memory.
    typedef struct packed {
        logic [31:0]        deadline;
        logic [31:0]        start_stamp;
        logic [COUNT_W-1:0] miss_count;
    } entry_t;

    // Result payload, first field in the highest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] overdue_count;
        logic               recover_now;
        logic               run_flag;
        logic [2:0]         out_channel;
    } result_t;

endpackage

// ----- design/mcdw_table.sv -----
// ----------------------------------------------------------------------------
// mcdw_table
// Channel table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mcdw_table
    import mcdw_pkg::*;
#(
    parameter int DEPTH = CHANNELS_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t mem_array [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/multi_channel_deadline_watchdog_top.sv -----
// ----------------------------------------------------------------------------
// multi_channel_deadline_watchdog_top
// Deadline watchdog over a table of channels, driven by a command stream.
// ----------------------------------------------------------------------------
// Each request carries a command, a channel, a deadline and a microsecond
// timestamp. Register stores a deadline on a fresh channel, start arms it,
// end disarms it and clears its overdue count, stop-all disarms every
// channel, recover clears the count and always answers with one result, and
// check walks the whole table and answers with one result per overdue
// channel (elapsed time, taken modulo 2^32, above the deadline), ascending,
// with tlast on the final one; a check with nothing overdue answers nothing.
// Deadline, start stamp and overdue count live in a one-port-read,
// one-port-write synchronous memory; registered and running flags are
// flip-flops. Stop-all and unused codes finish in the cycle they are accepted;
// register, start, end and recover read the memory, then write back; check
// walks the table, reading one entry per cycle while the walk is not held and
// writing the updated count back as it evaluates that entry. A result that
// cannot move into the output register because the previous one is still
// unclaimed keeps the block busy. A new request is taken
// once the previous one has finished; finished results wait in the output
// register without holding up the next request.
// ----------------------------------------------------------------------------
module multi_channel_deadline_watchdog_top
    import mcdw_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, low bit up: cmd[2:0], channel[5:3], expected_us[37:6],
    // time_us[69:38], zero fill [71:70]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, low bit up: out_channel[2:0], run_flag[3], recover_now[4],
    // overdue_count[20:5], zero fill [23:21]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    // Request fields as they arrive
    logic [2:0]  s_cmd;
    logic [2:0]  s_channel;
    logic [31:0] s_expected_us;
    logic [31:0] s_time_us;
    logic        s_accept;

    assign s_cmd         = s_tdata[2:0];
    assign s_channel     = s_tdata[5:3];
    assign s_expected_us = s_tdata[37:6];
    assign s_time_us     = s_tdata[69:38];

    // Control state
    state_t             state_reg, state_next;
    logic [CHANNELS-1:0] registered_reg, registered_next;
    logic [CHANNELS-1:0] running_reg, running_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               ev_valid_reg, ev_valid_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [RES_W-1:0]   res_cnt_reg, res_cnt_next;
    logic               m_valid_reg, m_valid_next;

    // Payload registers
    cmd_t               req_cmd_reg, req_cmd_next;
    logic [2:0]         req_ch_reg, req_ch_next;
    logic [31:0]        req_exp_reg, req_exp_next;
    logic [31:0]        req_time_reg, req_time_next;
    logic [CH_W-1:0]    ev_idx_reg, ev_idx_next;
    logic [2:0]         pend_ch_reg, pend_ch_next;
    logic [COUNT_W-1:0] pend_cnt_reg, pend_cnt_next;
    result_t            m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    // Table memory ports
    logic            rd_en;
    logic [CH_W-1:0] rd_addr;
    entry_t          rd_data;
    logic            wr_en;
    logic [CH_W-1:0] wr_addr;
    entry_t          wr_data;

    // Request decode
    logic [CH_W-1:0] req_idx;
    logic            req_in_range;
    logic            req_known;

    // Walk evaluation
    logic [31:0]        ev_elapsed;
    logic               ev_overdue;
    logic [COUNT_W-1:0] ev_count;
    logic               ev_record;
    logic               stall;
    logic               walk_done;
    logic               out_free;

    // Output loading
    logic    load_out;
    result_t out_data;
    logic    out_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign req_idx      = CH_W'(req_ch_reg);
    assign req_in_range = {29'd0, req_ch_reg} < 32'(CHANNELS);
    assign req_known    = req_in_range && registered_reg[req_idx];

    // Elapsed time tolerates timestamp wrap through modulo subtraction
    assign ev_elapsed = req_time_reg - rd_data.start_stamp;
    assign ev_overdue = ev_valid_reg && registered_reg[ev_idx_reg] &&
                        running_reg[ev_idx_reg] && (ev_elapsed > rd_data.deadline);
    assign ev_count   = (rd_data.miss_count == COUNT_MAX) ? rd_data.miss_count
                                                          : rd_data.miss_count + 1'b1;
    assign ev_record  = ev_overdue && (res_cnt_reg < RES_W'(MAX_RESULTS));
    // Hold the walk when a new result needs the pending slot and the
    // output register cannot take the old one
    assign stall      = ev_record && pend_valid_reg && !out_free;
    assign walk_done  = (rd_idx_reg == CNT_W'(CHANNELS)) && !ev_valid_reg;

    mcdw_table #(
        .DEPTH (CHANNELS)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    priority case (s_cmd)
                        CMD_REGISTER, CMD_START, CMD_END, CMD_RECOVER: begin
                            state_next = ST_OP;
                        end
                        CMD_CHECK: begin
                            state_next = ST_CHECK;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_OP: begin
                if (req_cmd_reg != CMD_RECOVER || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (walk_done) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb begin
        registered_next = registered_reg;
        running_next    = running_reg;
        rd_idx_next     = rd_idx_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_ch_next    = pend_ch_reg;
        pend_cnt_next   = pend_cnt_reg;
        res_cnt_next    = res_cnt_reg;
        req_cmd_next    = req_cmd_reg;
        req_ch_next     = req_ch_reg;
        req_exp_next    = req_exp_reg;
        req_time_next   = req_time_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = req_idx;
        wr_data         = rd_data;
        load_out        = 1'b0;
        out_data        = '0;
        out_last        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                // Read the addressed entry ahead of the modify cycle
                rd_en   = s_tvalid;
                rd_addr = CH_W'(s_channel);
                if (s_accept) begin
                    req_cmd_next  = cmd_t'(s_cmd);
                    req_ch_next   = s_channel;
                    req_exp_next  = s_expected_us;
                    req_time_next = s_time_us;
                    if (s_cmd == CMD_STOP_ALL) begin
                        running_next = '0;
                    end
                    if (s_cmd == CMD_CHECK) begin
                        rd_idx_next     = '0;
                        ev_valid_next   = 1'b0;
                        pend_valid_next = 1'b0;
                        res_cnt_next    = '0;
                    end
                end
            end
            ST_OP: begin
                priority case (req_cmd_reg)
                    CMD_REGISTER: begin
                        if (req_in_range && !registered_reg[req_idx]) begin
                            registered_next[req_idx] = 1'b1;
                            running_next[req_idx]    = 1'b0;
                            wr_en                    = 1'b1;
                            wr_data.deadline         = req_exp_reg;
                            wr_data.start_stamp      = req_time_reg;
                            wr_data.miss_count       = '0;
                        end
                    end
                    CMD_START: begin
                        if (req_known) begin
                            running_next[req_idx] = 1'b1;
                            wr_en                 = 1'b1;
                            wr_data.start_stamp   = req_time_reg;
                        end
                    end
                    CMD_END: begin
                        if (req_known) begin
                            running_next[req_idx] = 1'b0;
                            wr_en                 = 1'b1;
                            wr_data.miss_count    = '0;
                        end
                    end
                    CMD_RECOVER: begin
                        if (out_free) begin
                            load_out             = 1'b1;
                            out_last             = 1'b1;
                            out_data.out_channel = req_ch_reg;
                            out_data.run_flag    = req_in_range && running_reg[req_idx];
                            out_data.recover_now = req_known;
                            out_data.overdue_count = '0;
                            if (req_known) begin
                                wr_en              = 1'b1;
                                wr_data.miss_count = '0;
                            end
                        end
                    end
                    default: begin
                        wr_en = 1'b0;
                    end
                endcase
            end
            ST_CHECK: begin
                if (!stall) begin
                    // Evaluate the entry held on the read data and write back its count if it is overdue
                    if (ev_overdue) begin
                        wr_en              = 1'b1;
                        wr_addr            = ev_idx_reg;
                        wr_data.miss_count = ev_count;
                    end
                    if (ev_record) begin
                        if (pend_valid_reg) begin
                            load_out               = 1'b1;
                            out_data.out_channel   = pend_ch_reg;
                            out_data.run_flag      = 1'b1;
                            out_data.recover_now   = 1'b1;
                            out_data.overdue_count = pend_cnt_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_ch_next    = 3'(ev_idx_reg);
                        pend_cnt_next   = ev_count;
                        res_cnt_next    = res_cnt_reg + 1'b1;
                    end
                    // Issue the read of the next entry
                    if (rd_idx_reg < CNT_W'(CHANNELS)) begin
                        rd_en         = 1'b1;
                        rd_addr       = rd_idx_reg[CH_W-1:0];
                        ev_valid_next = 1'b1;
                        ev_idx_next   = rd_idx_reg[CH_W-1:0];
                        rd_idx_next   = rd_idx_reg + 1'b1;
                    end else begin
                        ev_valid_next = 1'b0;
                    end
                end
            end
            ST_FLUSH: begin
                // Release the held result as the final one of the check
                if (pend_valid_reg && out_free) begin
                    load_out               = 1'b1;
                    out_last               = 1'b1;
                    out_data.out_channel   = pend_ch_reg;
                    out_data.run_flag      = 1'b1;
                    out_data.recover_now   = 1'b1;
                    out_data.overdue_count = pend_cnt_reg;
                    pend_valid_next        = 1'b0;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Output register
    always_comb begin
        m_data_next = m_data_reg;
        m_last_next = m_last_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = out_data;
            m_last_next  = out_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            registered_reg <= '0;
            running_reg    <= '0;
            rd_idx_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            registered_reg <= registered_next;
            running_reg    <= running_next;
            rd_idx_reg     <= rd_idx_next;
            ev_valid_reg   <= ev_valid_next;
            pend_valid_reg <= pend_valid_next;
            res_cnt_reg    <= res_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_cmd_reg  <= req_cmd_next;
        req_ch_reg   <= req_ch_next;
        req_exp_reg  <= req_exp_next;
        req_time_reg <= req_time_next;
        ev_idx_reg   <= ev_idx_next;
        pend_ch_reg  <= pend_ch_next;
        pend_cnt_reg <= pend_cnt_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - $bits(result_t))'(0), m_data_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ----- design/mcdw_checker.sv -----
// ----------------------------------------------------------------------------
// mcdw_checker
// Port-level checks of the deadline watchdog, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcdw_checker
    import mcdw_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // A stalled result holds
    `ASSERT_NXT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready), (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))

    // Stop-all finishes in its own cycle
    `ASSERT_NXT(a_stop_all_quick, aclk, aresetn, (s_tvalid && s_tready && s_tdata[2:0] == CMD_STOP_ALL), (s_tready))

    // A check does not finish in the cycle it is accepted
    `ASSERT_NXT(a_check_busy, aclk, aresetn, (s_tvalid && s_tready && s_tdata[2:0] == CMD_CHECK), (!s_tready))

    // A result without recovery comes only from recover and is its last
    `ASSERT_IMP(a_norecover_last, aclk, aresetn, (m_tvalid && !m_tdata[4]), (m_tlast))

    // A zero count comes only from recover, whose result is the last
    `ASSERT_IMP(a_zero_count_last, aclk, aresetn, (m_tvalid && m_tdata[20:5] == 16'd0), (m_tlast))

endmodule

bind multi_channel_deadline_watchdog_top mcdw_checker u_mcdw_checker (.*);

// ----- tb/multi_channel_deadline_watchdog_top_tb.sv -----
// ----------------------------------------------------------------------------
// multi_channel_deadline_watchdog_top_tb
// Self-checking bench for the deadline watchdog command stream.
// ----------------------------------------------------------------------------
// Drives requests on the s_ stream and checks every result on the m_ stream
// against a watchdog table kept inside the bench. A short table of directed
// requests comes first. Random requests over a moving timestamp follow, with
// bursty sender gaps and a changing receiver stall pattern.
// ----------------------------------------------------------------------------
module multi_channel_deadline_watchdog_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcdw_pkg::*;

    localparam int CHANNELS       = CHANNELS_DEFAULT;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 456;
    localparam int CYCLE_LIMIT    = 400_000;
    localparam int DRAIN_CYCLES   = CHANNELS + 8;
    localparam int PRINT_LIMIT    = 20;
    localparam int RESULT_W       = $bits(result_t);

    // Command codes the package leaves unnamed; the block must ignore them.
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    // One result as seen on the bus: payload plus the tlast flag.
    typedef struct packed {
        logic    last;
        result_t payload;
    } wd_report_t;

    // How a directed row is checked.
    typedef enum logic [1:0] {
        FROM_MODEL,   // expected results come from the watchdog table below
        NO_RESULT,    // row must produce nothing
        ONE_RESULT    // row must produce exactly the typed result
    } check_kind_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  chan;
        logic [31:0] deadline_us;
        logic [31:0] stamp_us;
        check_kind_t kind;
        wd_report_t  typed;
    } plan_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Watchdog table as the bench sees it.
    logic               chan_registered [CHANNELS];
    logic               chan_running    [CHANNELS];
    logic [31:0]        chan_deadline   [CHANNELS];
    logic [31:0]        chan_started    [CHANNELS];
    logic [COUNT_W-1:0] chan_misses     [CHANNELS];

    wd_report_t  pending_reports [$];
    plan_row_t   directed_plan [$];

    int unsigned cycle_count     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    int unsigned directed_sent   = 0;
    int unsigned random_sent     = 0;

    // Sender and receiver pacing.
    bit          tx_free_run = 1'b0;
    bit          rx_free_run = 1'b0;
    int unsigned burst_left  = 0;
    int unsigned rx_hold     = 0;
    int unsigned rx_mode     = 0;
    logic [15:0] rx_mask     = 16'h0001;

    // Microsecond timestamp for the random part, advanced or jumped per request.
    logic [31:0] wall_us = '0;

    multi_channel_deadline_watchdog_top #(
        .CHANNELS (CHANNELS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    // Bound the run; a hung handshake or a missing result ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_reports.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic wd_report_t make_report(input logic [2:0] chan, input logic run,
                                               input logic rec,
                                               input logic [COUNT_W-1:0] misses,
                                               input logic fin);
        wd_report_t r;
        r.payload.out_channel   = chan;
        r.payload.run_flag      = run;
        r.payload.recover_now   = rec;
        r.payload.overdue_count = misses;
        r.last                  = fin;
        return r;
    endfunction

    // Apply one accepted request to the bench's table. When keep is set,
    // queue the results it causes; typed rows queue their own instead.
    function automatic void predict_watchdog(input logic [2:0] cmd, input logic [2:0] chan,
                                             input logic [31:0] deadline_us,
                                             input logic [31:0] stamp_us, input bit keep);
        wd_report_t  batch [MAX_RESULTS];
        int          idx;
        int          n;
        bit          in_table;
        bit          known;
        logic [31:0] elapsed;
        idx      = int'(chan);
        in_table = idx < CHANNELS;
        known    = in_table && chan_registered[idx];
        n        = 0;
        case (cmd)
            CMD_REGISTER: begin
                // A second register on a live channel keeps the old deadline.
                if (in_table && !chan_registered[idx]) begin
                    chan_registered[idx] = 1'b1;
                    chan_deadline[idx]   = deadline_us;
                    chan_started[idx]    = stamp_us;
                    chan_running[idx]    = 1'b0;
                    chan_misses[idx]     = '0;
                end
            end
            CMD_START: begin
                if (known) begin
                    chan_started[idx] = stamp_us;
                    chan_running[idx] = 1'b1;
                end
            end
            CMD_END: begin
                if (known) begin
                    chan_running[idx] = 1'b0;
                    chan_misses[idx]  = '0;
                end
            end
            CMD_RECOVER: begin
                if (known)
                    chan_misses[idx] = '0;
                batch[0] = make_report(chan, in_table ? chan_running[idx] : 1'b0, known,
                                       in_table ? chan_misses[idx] : '0, 1'b1);
                n = 1;
            end
            CMD_CHECK: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (chan_registered[i] && chan_running[i]) begin
                        // Wrapping subtraction tolerates timestamp rollover.
                        elapsed = stamp_us - chan_started[i];
                        if (elapsed > chan_deadline[i]) begin
                            if (chan_misses[i] != COUNT_MAX)
                                chan_misses[i] = chan_misses[i] + 1'b1;
                            if (n < MAX_RESULTS) begin
                                batch[n] = make_report(i[2:0], 1'b1, 1'b1, chan_misses[i],
                                                       1'b0);
                                n++;
                            end
                        end
                    end
                end
                if (n > 0)
                    batch[n-1].last = 1'b1;
            end
            CMD_STOP_ALL: begin
                for (int i = 0; i < CHANNELS; i++)
                    chan_running[i] = 1'b0;
            end
            default: ;
        endcase
        if (keep) begin
            for (int k = 0; k < n; k++)
                pending_reports = {pending_reports, batch[k]};
        end
    endfunction

    function automatic void add_row(input logic [2:0] cmd, input logic [2:0] chan,
                                    input logic [31:0] deadline_us,
                                    input logic [31:0] stamp_us, input check_kind_t kind,
                                    input wd_report_t typed);
        plan_row_t row;
        row.cmd         = cmd;
        row.chan        = chan;
        row.deadline_us = deadline_us;
        row.stamp_us    = stamp_us;
        row.kind        = kind;
        row.typed       = typed;
        directed_plan   = {directed_plan, row};
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatch_count < PRINT_LIMIT)
            $display("Mismatch at cycle %0d: %s got 0x%0h, want 0x%0h",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Send one request. Drive at the falling edge, hold until accepted at a
    // rising edge, then predict from what was accepted.
    task automatic push_request(input logic [2:0] cmd, input logic [2:0] chan,
                                input logic [31:0] deadline_us, input logic [31:0] stamp_us,
                                input check_kind_t kind, input wd_report_t typed);
        int unsigned gap;
        gap = 0;
        if (!tx_free_run && burst_left == 0) begin
            gap        = $urandom_range(1, 14);
            burst_left = $urandom_range(1, 12);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, stamp_us, deadline_us, chan, cmd};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_watchdog(cmd, chan, deadline_us, stamp_us, kind == FROM_MODEL);
        if (kind == ONE_RESULT)
            pending_reports = {pending_reports, typed};
        if (burst_left > 0)
            burst_left--;
        @(negedge aclk);
    endtask

    // Receiver: long stretches of a fixed stall style, always ready when
    // the free-run flag is up.
    always @(negedge aclk) begin
        if (rx_free_run || !aresetn) begin
            m_tready <= 1'b1;
        end else begin
            if (rx_hold == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_hold = $urandom_range(16, 96);
                rx_mask = 16'($urandom());
                rx_mask[0] = 1'b1;
            end
            rx_hold = rx_hold - 1;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: begin
                    m_tready <= rx_mask[0];
                    rx_mask = {rx_mask[0], rx_mask[15:1]};
                end
                2: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // Compare every accepted result with the oldest pending one.
    always @(posedge aclk) begin : result_monitor
        wd_report_t got;
        wd_report_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got.payload = m_tdata[RESULT_W-1:0];
            got.last    = m_tlast;
            results_checked++;
            if (pending_reports.size() == 0) begin
                report_mismatch("result with nothing pending", got, 0);
            end else begin
                want = pending_reports.pop_front();
                if (got.payload.out_channel !== want.payload.out_channel)
                    report_mismatch("out_channel", got.payload.out_channel,
                                    want.payload.out_channel);
                if (got.payload.run_flag !== want.payload.run_flag)
                    report_mismatch("run_flag", got.payload.run_flag,
                                    want.payload.run_flag);
                if (got.payload.recover_now !== want.payload.recover_now)
                    report_mismatch("recover_now", got.payload.recover_now,
                                    want.payload.recover_now);
                if (got.payload.overdue_count !== want.payload.overdue_count)
                    report_mismatch("overdue_count", got.payload.overdue_count,
                                    want.payload.overdue_count);
                if (got.last !== want.last)
                    report_mismatch("tlast", got.last, want.last);
            end
        end
    end

    initial begin : stimulus
        wd_report_t  none;
        plan_row_t   row;
        int unsigned pick;
        logic [2:0]  cmd;
        logic [31:0] deadline_us;

        none = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            chan_registered[i] = 1'b0;
            chan_running[i]    = 1'b0;
            chan_deadline[i]   = '0;
            chan_started[i]    = '0;
            chan_misses[i]     = '0;
        end

        // Directed table. Typed results are the ones readable at a glance.
        // Recover right after reset: nothing registered, nothing fires.
        add_row(CMD_RECOVER, 3'd0, 32'd0, 32'd0, ONE_RESULT,
                make_report(3'd0, 1'b0, 1'b0, '0, 1'b1));
        add_row(CMD_CHECK, 3'd0, 32'd0, 32'd0, FROM_MODEL, none);
        // Start and end on channels never registered: drop them.
        add_row(CMD_START, 3'd1, 32'd0, 32'd50, NO_RESULT, none);
        add_row(CMD_END, 3'd2, 32'd0, 32'd60, NO_RESULT, none);
        // Unused command codes: no effect, no result.
        add_row(CMD_SPARE6, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, NO_RESULT, none);
        add_row(CMD_SPARE7, 3'd3, 32'h5555_5555, 32'hAAAA_AAAA, NO_RESULT, none);
        // Extreme deadlines: zero on channel 0, all ones on channel 7.
        add_row(CMD_REGISTER, 3'd0, 32'd0, 32'd0, NO_RESULT, none);
        add_row(CMD_REGISTER, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, NO_RESULT, none);
        // Re-register keeps the old deadline of zero.
        add_row(CMD_REGISTER, 3'd0, 32'd1000, 32'd20, NO_RESULT, none);
        add_row(CMD_START, 3'd0, 32'd0, 32'hFFFF_FFF0, FROM_MODEL, none);
        add_row(CMD_START, 3'd7, 32'd0, 32'd0, FROM_MODEL, none);
        // Elapsed equal to deadline is not overdue.
        add_row(CMD_CHECK, 3'd0, 32'd0, 32'hFFFF_FFF0, FROM_MODEL, none);
        // Timestamp wrapped past zero: channel 0 overdue.
        add_row(CMD_CHECK, 3'd5, 32'd0, 32'd5, FROM_MODEL, none);
        // Channel 7 elapsed reaches all ones and still does not exceed.
        add_row(CMD_CHECK, 3'd6, 32'd0, 32'hFFFF_FFFF, FROM_MODEL, none);
        add_row(CMD_RECOVER, 3'd0, 32'd0, 32'd0, ONE_RESULT,
                make_report(3'd0, 1'b1, 1'b1, '0, 1'b1));
        add_row(CMD_REGISTER, 3'd3, 32'd10, 32'd100, FROM_MODEL, none);
        add_row(CMD_START, 3'd3, 32'd0, 32'd100, FROM_MODEL, none);
        add_row(CMD_REGISTER, 3'd5, 32'd0, 32'd0, FROM_MODEL, none);
        add_row(CMD_START, 3'd5, 32'd0, 32'd0, FROM_MODEL, none);
        // Several overdue channels in one walk.
        add_row(CMD_CHECK, 3'd0, 32'd0, 32'd200, FROM_MODEL, none);
        add_row(CMD_END, 3'd3, 32'd0, 32'd210, FROM_MODEL, none);
        add_row(CMD_STOP_ALL, 3'd0, 32'd0, 32'd220, FROM_MODEL, none);
        add_row(CMD_CHECK, 3'd0, 32'd0, 32'd1000, FROM_MODEL, none);
        add_row(CMD_RECOVER, 3'd5, 32'd0, 32'd1010, ONE_RESULT,
                make_report(3'd5, 1'b0, 1'b1, '0, 1'b1));
        // Recover on an unregistered channel reports but does not fire.
        add_row(CMD_RECOVER, 3'd6, 32'd0, 32'd1020, ONE_RESULT,
                make_report(3'd6, 1'b0, 1'b0, '0, 1'b1));

        // Hold reset, then release at a falling edge.
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_plan[r]) begin
            row = directed_plan[r];
            push_request(row.cmd, row.chan, row.deadline_us, row.stamp_us, row.kind,
                         row.typed);
            directed_sent++;
        end

        // Random part: mostly starts and checks over a moving clock so that
        // channels go overdue, with ends, recovers, stop-all and junk codes.
        wall_us = 32'd5000;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                wall_us = $urandom();
            else if (pick < 9)
                wall_us = 32'hFFFF_FF00 + $urandom_range(0, 255);
            else
                wall_us = wall_us + $urandom_range(0, 60);

            pick = $urandom_range(0, 99);
            if (pick < 8)       cmd = CMD_REGISTER;
            else if (pick < 36) cmd = CMD_START;
            else if (pick < 46) cmd = CMD_END;
            else if (pick < 56) cmd = CMD_RECOVER;
            else if (pick < 90) cmd = CMD_CHECK;
            else if (pick < 94) cmd = CMD_STOP_ALL;
            else if (pick < 97) cmd = CMD_SPARE6;
            else                cmd = CMD_SPARE7;

            if ($urandom_range(0, 3) == 0)
                deadline_us = $urandom();
            else
                deadline_us = $urandom_range(0, 400);

            // Short stretches with no sender gaps, and with no receiver stalls.
            if (k % 120 == 60)
                tx_free_run = 1'b1;
            else if (k % 120 == 90)
                tx_free_run = 1'b0;
            if (k % 120 == 0)
                rx_free_run = 1'b1;
            else if (k % 120 == 30)
                rx_free_run = 1'b0;

            push_request(cmd, 3'($urandom_range(0, 7)), deadline_us, wall_us, FROM_MODEL,
                         none);
            random_sent++;
        end
        s_tvalid <= 1'b0;
        rx_free_run = 1'b0;

        // Drain: wait out pending results, then give the block time to show
        // anything extra.
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests: %0d directed, %0d random",
                 directed_sent + random_sent, directed_sent, random_sent);
        $display("Checked %0d results over %0d cycles, %0d mismatches",
                 results_checked, cycle_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- multi_channel_deadline_watchdog_top.f -----
+incdir+design
design/mcdw_pkg.sv
design/mcdw_table.sv
design/multi_channel_deadline_watchdog_top.sv
design/mcdw_checker.sv
tb/multi_channel_deadline_watchdog_top_tb.sv
